// ----- rtl/r2b_pkg.sv -----
// ----------------------------------------------------------------------------
// r2b_pkg
// Shared types and constants for the raster to 8x8 block splitter.
// ----------------------------------------------------------------------------
package r2b_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int IMG_W_BITS = 11;
    localparam int IMG_H_BITS = 13;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

    localparam int RESET_SIZE = 64;
    localparam int MIN_SIZE   = 4;

    // grey = (sum * 683) >> 11, exact for sums below 2048
    localparam logic [20:0] DIV3_RECIP = 21'd683;
    localparam int          DIV3_SHIFT = 11;

    // block column index, wide enough for the largest supported row width
    localparam int COL_BLK_W = 10;

    // queue depths
    localparam int DESC_DEPTH = 4;
    localparam int OUT_DEPTH  = 4;
    localparam int OUT_CNT_W  = $clog2(OUT_DEPTH + 1);

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pixel;

    typedef struct packed {
        logic [7:0] grey;
        logic       block_last;
        logic       frame_last;
    } t_block_pixel;

    // one finished block waiting for readout
    typedef struct packed {
        logic [COL_BLK_W-1:0] col_blk;   // block column (bx / 8)
        logic                 row_half;  // which half of the line store
        logic [3:0]           rows_used; // real rows in block, 1..8
        logic [3:0]           cols_used; // real columns in block, 1..8
        logic                 frame_end;
    } t_block_desc;

    typedef enum logic {
        BK_IDLE,
        BK_RUN
    } t_back_state;

endpackage

// ----- rtl/r2b_fifo.sv -----
// ----------------------------------------------------------------------------
// r2b_fifo
// Small register queue with occupancy count.
// ----------------------------------------------------------------------------
module r2b_fifo #(
    parameter type T         = logic,
    parameter int  DEPTH     = 4,
    localparam int PW        = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNTW      = $clog2(DEPTH + 1)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  T                i_data,
    output logic            o_full,
    input  logic            i_pop,
    output T                o_data,
    output logic            o_empty,
    output logic [CNTW-1:0] o_count
);

    T                r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNTW-1:0] r_count, n_count;
    logic            do_push, do_pop;

    assign o_full  = (r_count == CNTW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_data  = r_mem[r_rd_ptr];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CNTW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNTW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ----- rtl/r2b_line_store.sv -----
// ----------------------------------------------------------------------------
// r2b_line_store
// 16-row grey line store, one write port and one registered read port.
// ----------------------------------------------------------------------------
module r2b_line_store #(
    parameter int  MAX_WIDTH = 1024,
    localparam int CW        = $clog2(MAX_WIDTH),
    localparam int ADDR_W    = 4 + CW,
    localparam int DEPTH     = 1 << ADDR_W
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [7:0]        i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [7:0]        o_rd_data
);

    // address is {store row, column}; no reset, never read before written
    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    assign o_rd_data = r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

// ----- rtl/r2b_front.sv -----
// ----------------------------------------------------------------------------
// r2b_front
// Pixel intake: grey conversion, raster counters, block completion detect.
// ----------------------------------------------------------------------------
module r2b_front import r2b_pkg::*; #(
    parameter int  MAX_WIDTH  = 1024,
    parameter int  MAX_HEIGHT = 4096,
    localparam int CW         = $clog2(MAX_WIDTH),
    localparam int RW         = ($clog2(MAX_HEIGHT) > 4) ? $clog2(MAX_HEIGHT) : 4,
    localparam int WW         = $clog2(MAX_WIDTH + 1),
    localparam int HW         = $clog2(MAX_HEIGHT + 1),
    localparam int ADDR_W     = 4 + CW
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_push,
    input  t_pixel                i_pixel,
    output logic                  o_full,
    output logic                  o_wr_en,
    output logic [ADDR_W-1:0]     o_wr_addr,
    output logic [7:0]            o_wr_data,
    output logic                  o_desc_push,
    output t_block_desc           o_desc,
    input  logic                  i_desc_full,
    input  logic                  i_back_busy
);

    localparam logic [WW-1:0] RST_WIDTH  =
        WW'((RESET_SIZE > MAX_WIDTH) ? MAX_WIDTH : RESET_SIZE);
    localparam logic [HW-1:0] RST_HEIGHT =
        HW'((RESET_SIZE > MAX_HEIGHT) ? MAX_HEIGHT : RESET_SIZE);

    function automatic logic [WW-1:0] clamp_width(input logic [IMG_W_BITS-1:0] v);
        logic [WW-1:0] res;
        if (int'(v) < MIN_SIZE) begin
            res = WW'(MIN_SIZE);
        end else if (int'(v) > MAX_WIDTH) begin
            res = WW'(MAX_WIDTH);
        end else begin
            res = WW'(v);
        end
        return res;
    endfunction

    function automatic logic [HW-1:0] clamp_height(input logic [IMG_H_BITS-1:0] v);
        logic [HW-1:0] res;
        if (int'(v) < MIN_SIZE) begin
            res = HW'(MIN_SIZE);
        end else if (int'(v) > MAX_HEIGHT) begin
            res = HW'(MAX_HEIGHT);
        end else begin
            res = HW'(v);
        end
        return res;
    endfunction

    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic [WW-1:0] r_width, n_width;     // effective (clamped) sizes
    logic [HW-1:0] r_height, n_height;

    logic          accept;
    logic          band_start;
    logic          col_last, row_last, col_end, row_end;
    logic          cfg_hit;
    logic [9:0]    sum;
    logic [20:0]   prod;
    logic [WW-1:0] cols_left;
    logic [HW-1:0] rows_left;

    // a new 8-row band overwrites the store half that pending blocks may read
    assign band_start = (r_col == '0) && (r_row[2:0] == 3'd0);
    assign o_full     = i_desc_full || (band_start && i_back_busy);
    assign accept     = i_push && !o_full;

    assign sum  = 10'(i_pixel.red) + 10'(i_pixel.green) + 10'(i_pixel.blue);
    assign prod = 21'(sum) * DIV3_RECIP;

    assign o_wr_en   = accept;
    assign o_wr_addr = {r_row[3:0], r_col};
    assign o_wr_data = prod[DIV3_SHIFT +: 8];

    assign col_last = (WW'(r_col) == r_width - WW'(1));
    assign row_last = (HW'(r_row) == r_height - HW'(1));
    assign col_end  = (r_col[2:0] == 3'd7) || col_last;
    assign row_end  = (r_row[2:0] == 3'd7) || row_last;

    assign cols_left = r_width - WW'(r_col & ~CW'(7));
    assign rows_left = r_height - HW'(r_row & ~RW'(7));

    assign o_desc_push       = accept && col_end && row_end;
    assign o_desc.col_blk    = COL_BLK_W'(r_col >> 3);
    assign o_desc.row_half   = r_row[3];
    assign o_desc.rows_used  = (rows_left > HW'(8)) ? 4'd8 : 4'(rows_left);
    assign o_desc.cols_used  = (cols_left > WW'(8)) ? 4'd8 : 4'(cols_left);
    assign o_desc.frame_end  = col_last && row_last;

    assign cfg_hit = i_cfg_valid &&
                     ((i_cfg_index == REG_IMAGE_WIDTH) || (i_cfg_index == REG_IMAGE_HEIGHT));

    always_comb begin
        n_col    = r_col;
        n_row    = r_row;
        n_width  = r_width;
        n_height = r_height;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_IMAGE_WIDTH: begin
                    n_width = clamp_width(i_cfg_data[IMG_W_BITS-1:0]);
                end
                REG_IMAGE_HEIGHT: begin
                    n_height = clamp_height(i_cfg_data[IMG_H_BITS-1:0]);
                end
                default: begin
                end
            endcase
        end
        // a write to the width or height register restarts the frame
        if (cfg_hit) begin
            n_col = '0;
            n_row = '0;
        end else if (accept) begin
            if (col_last) begin
                n_col = '0;
                n_row = row_last ? '0 : r_row + RW'(1);
            end else begin
                n_col = r_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_width  <= RST_WIDTH;
            r_height <= RST_HEIGHT;
        end else begin
            r_col    <= n_col;
            r_row    <= n_row;
            r_width  <= n_width;
            r_height <= n_height;
        end
    end

endmodule

// ----- rtl/r2b_back.sv -----
// ----------------------------------------------------------------------------
// r2b_back
// Block readout: walks 64 mirrored store addresses per queued block.
// ----------------------------------------------------------------------------
module r2b_back import r2b_pkg::*; #(
    parameter int  MAX_WIDTH = 1024,
    localparam int CW        = $clog2(MAX_WIDTH),
    localparam int ADDR_W    = 4 + CW
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_desc_empty,
    input  t_block_desc          i_desc,
    output logic                 o_desc_pop,
    output logic                 o_busy,
    output logic                 o_rd_en,
    output logic [ADDR_W-1:0]    o_rd_addr,
    input  logic [7:0]           i_rd_data,
    output logic                 o_out_push,
    output t_block_pixel         o_out_data,
    input  logic [OUT_CNT_W-1:0] i_out_count
);

    // offset within the block after edge mirroring; may point above/left
    function automatic logic signed [4:0] mirror_off(input logic [2:0] idx,
                                                     input logic [3:0] used);
        logic signed [4:0] res;
        if ({1'b0, idx} < used) begin
            res = $signed({2'b00, idx});
        end else begin
            res = $signed({used, 1'b0}) - $signed({2'b00, idx}) - 5'sd1;
        end
        return res;
    endfunction

    t_back_state       r_state, n_state;
    t_block_desc       r_desc;
    logic [5:0]        r_idx;
    logic              r_pend, r_pend_last, r_pend_frame;
    logic              issue, credit_ok, last_idx;
    logic signed [4:0] row_off, col_off;
    logic [3:0]        store_row;
    logic [CW-1:0]     col_base, store_col;

    // room for the read in flight plus the new one
    assign credit_ok = (i_out_count + OUT_CNT_W'(r_pend)) < OUT_CNT_W'(OUT_DEPTH);
    assign last_idx  = &r_idx;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_desc_empty) begin
                    n_state = BK_RUN;
                end
            end
            BK_RUN: begin
                if (issue && last_idx) begin
                    n_state = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_comb begin
        o_desc_pop = 1'b0;
        issue      = 1'b0;
        o_busy     = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                o_desc_pop = !i_desc_empty;
            end
            BK_RUN: begin
                issue  = credit_ok;
                o_busy = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign row_off   = mirror_off(r_idx[5:3], r_desc.rows_used);
    assign col_off   = mirror_off(r_idx[2:0], r_desc.cols_used);
    assign store_row = {r_desc.row_half, 3'b000} + 4'(row_off);
    assign col_base  = CW'({r_desc.col_blk, 3'b000});
    assign store_col = col_base + CW'(col_off);

    assign o_rd_en   = issue;
    assign o_rd_addr = {store_row, store_col};

    assign o_out_push            = r_pend;
    assign o_out_data.grey       = i_rd_data;
    assign o_out_data.block_last = r_pend_last;
    assign o_out_data.frame_last = r_pend_frame;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_idx   <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= issue;
            if (o_desc_pop) begin
                r_idx <= '0;
            end else if (issue) begin
                r_idx <= r_idx + 6'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_desc_pop) begin
            r_desc <= i_desc;
        end
        r_pend_last  <= last_idx;
        r_pend_frame <= last_idx && r_desc.frame_end;
    end

endmodule

// ----- rtl/raster_to_block_splitter_top.sv -----
// Rate: one pixel request taken per cycle unless intake stalls; a block's 64 grey pixels
// leave at one per cycle while the output queue has room, bounded by the single read
// port of the line store; the back end starts a new block only after the last read.
// Intake stalls at the first pixel of each 8-row band until earlier blocks are read out,
// and whenever four finished blocks already wait for readout.
// Reset (synchronous, active low) zeroes the raster counters, sets width/height to 64.
// ----------------------------------------------------------------------------
// raster_to_block_splitter_top
// RGB raster pixels in, grey 8x8 blocks out, edge blocks filled by mirroring.
// ----------------------------------------------------------------------------
module raster_to_block_splitter_top import r2b_pkg::*; #(
    parameter int  MAX_WIDTH  = 1024,
    parameter int  MAX_HEIGHT = 4096,
    localparam int CW         = $clog2(MAX_WIDTH),
    localparam int ADDR_W     = 4 + CW
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // pixel intake, queue style
    input  logic                  push,
    input  t_pixel                i_pixel,
    output logic                  full,
    // block pixel output, queue style
    output logic                  empty,
    input  logic                  pop,
    output t_block_pixel          o_block_pixel
);

    // Front end: converts each pixel to grey, writes it to the line store and
    // posts a descriptor when the pixel closes an 8x8 region (clipped at the
    // image edges). Back end: pulls descriptors and reads the 64 store
    // locations, mirroring rows/columns that fall past the image edge.

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data;

    logic              desc_push, desc_pop, desc_full, desc_empty;
    t_block_desc       desc_in, desc_out;

    logic              back_busy;
    logic              front_hold;   // blocks still to be read from the store

    logic                 out_push;
    t_block_pixel         out_data;
    logic [OUT_CNT_W-1:0] out_count;

    // configuration must arrive only while idle (the user's duty, unenforced); always taken
    assign o_cfg_ready = 1'b1;

    assign front_hold = back_busy || !desc_empty;

    r2b_front #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_HEIGHT  (MAX_HEIGHT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_push      (push),
        .i_pixel     (i_pixel),
        .o_full      (full),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_desc_push (desc_push),
        .o_desc      (desc_in),
        .i_desc_full (desc_full),
        .i_back_busy (front_hold)
    );

    r2b_line_store #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // short descriptor queue decoupling intake from readout
    r2b_fifo #(
        .T       (t_block_desc),
        .DEPTH   (DESC_DEPTH)
    ) u_desc_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (desc_push),
        .i_data  (desc_in),
        .o_full  (desc_full),
        .i_pop   (desc_pop),
        .o_data  (desc_out),
        .o_empty (desc_empty),
        .o_count ()
    );

    r2b_back #(
        .MAX_WIDTH    (MAX_WIDTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_desc_empty (desc_empty),
        .i_desc       (desc_out),
        .o_desc_pop   (desc_pop),
        .o_busy       (back_busy),
        .o_rd_en      (rd_en),
        .o_rd_addr    (rd_addr),
        .i_rd_data    (rd_data),
        .o_out_push   (out_push),
        .o_out_data   (out_data),
        .i_out_count  (out_count)
    );

    // result queue; the back end only reads when a slot is guaranteed,
    // so its full flag is not needed
    r2b_fifo #(
        .T       (t_block_pixel),
        .DEPTH   (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (out_data),
        .o_full  (),
        .i_pop   (pop),
        .o_data  (o_block_pixel),
        .o_empty (empty),
        .o_count (out_count)
    );

endmodule

// ----- verif/tb_raster_to_block_splitter_top.sv -----
// ----------------------------------------------------------------------------
// tb_raster_to_block_splitter_top
// Self-checking bench for the raster to 8x8 block splitter. RGB pixels go in
// as queue pushes and every popped grey block pixel is compared with a
// behavioural model of the splitter kept in the bench (grey mean, 16-row line
// store, mirrored edges). A short script and directed sizes come first, then random
// image sizes and pixels with random idling on both sides, then a calm closing frame.
// ----------------------------------------------------------------------------
module tb_raster_to_block_splitter_top;
    timeunit 1ns;
    timeprecision 1ps;

    import r2b_pkg::*;

    localparam int MAX_W       = 1024;
    localparam int MAX_H       = 4096;
    localparam int BLK         = 8;
    localparam int STORE_ROWS  = 16;
    // margin for the pipe to empty once every block pixel has been popped
    localparam int SETTLE_CYCLES = 8;
    // long receiver hold-off so that the splitter backs up into its intake
    localparam int HOLD_CYCLES = 400;
    // longest legal stretch without any request taken is the hold-off above;
    // random stalls and gaps are shorter than that, so this is ample
    localparam int QUIET_LIMIT = 4000;
    // pixels in the random part; the last frame may run up to RAND_SPILL over
    localparam int RAND_ITEMS  = 48;
    localparam int RAND_SPILL  = 16;

    // index beyond the register file: ignored, raster position kept
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(3);

    typedef enum logic {
        STEP_WRITE,
        STEP_PIXEL
    } t_step_kind;

    typedef struct {
        t_step_kind              kind;
        logic [CFG_IDX_W-1:0]    index;
        logic [CFG_DATA_W-1:0]   data;
        t_pixel                  px;
        int                      reps;
        bit                      typed;      // block contents known without the model
        logic [7:0]              grey;
        bit                      frame_last;
    } t_script_step;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  pix_push  = 1'b0;
    t_pixel                pix_in    = '0;
    logic                  pix_full;
    logic                  blk_empty;
    logic                  blk_pop   = 1'b0;
    t_block_pixel          blk_out;

    // model state
    logic [7:0]            grey_store [STORE_ROWS*MAX_W];
    int                    raster_row = 0;
    int                    raster_col = 0;
    logic [IMG_W_BITS-1:0] width_reg  = IMG_W_BITS'(RESET_SIZE);
    logic [IMG_H_BITS-1:0] height_reg = IMG_H_BITS'(RESET_SIZE);

    t_block_pixel          grey_due [$];
    int                    n_errors    = 0;
    int                    quiet_cycles = 0;
    int                    rnd_items   = 0;
    bit                    calm        = 1'b0;
    bit                    hold_go     = 1'b0;

    // receiver state
    int                    hold_left  = 0;
    int                    stall_left = 0;
    bit                    hold_done  = 1'b0;

    // scripted part: 4x4 image via below-minimum register values
    t_script_step script [20] = '{
        '{STEP_WRITE, REG_IMAGE_WIDTH,  13'd0,     24'h000000, 0,  1'b0, 8'd0,   1'b0},
        '{STEP_WRITE, REG_IMAGE_HEIGHT, 13'd0,     24'h000000, 0,  1'b0, 8'd0,   1'b0},
        // all-white frame: every block pixel, mirrored or not, is full scale
        '{STEP_PIXEL, '0,               '0,        24'hFFFFFF, 16, 1'b1, 8'd255, 1'b1},
        '{STEP_PIXEL, '0,               '0,        24'h000000, 1,  1'b0, 8'd0,   1'b0},
        '{STEP_PIXEL, '0,               '0,        24'hFF0000, 1,  1'b0, 8'd0,   1'b0},
        '{STEP_PIXEL, '0,               '0,        24'h00FF00, 1,  1'b0, 8'd0,   1'b0},
        '{STEP_PIXEL, '0,               '0,        24'h0000FF, 1,  1'b0, 8'd0,   1'b0},
        '{STEP_PIXEL, '0,               '0,        24'hFFFFFE, 1,  1'b0, 8'd0,   1'b0},
        '{STEP_PIXEL, '0,               '0,        24'h010100, 1,  1'b0, 8'd0,   1'b0},
        '{STEP_PIXEL, '0,               '0,        24'h020201, 1,  1'b0, 8'd0,   1'b0},
        '{STEP_PIXEL, '0,               '0,        24'h804020, 1,  1'b0, 8'd0,   1'b0},
        // unused index mid-frame: must not restart the raster
        '{STEP_WRITE, REG_SPARE,        13'h1FFF,  24'h000000, 0,  1'b0, 8'd0,   1'b0},
        '{STEP_PIXEL, '0,               '0,        24'hAAAAAA, 1,  1'b0, 8'd0,   1'b0},
        '{STEP_PIXEL, '0,               '0,        24'hFEFFFF, 1,  1'b0, 8'd0,   1'b0},
        '{STEP_PIXEL, '0,               '0,        24'h550000, 1,  1'b0, 8'd0,   1'b0},
        '{STEP_PIXEL, '0,               '0,        24'h000101, 1,  1'b0, 8'd0,   1'b0},
        '{STEP_PIXEL, '0,               '0,        24'h030000, 1,  1'b0, 8'd0,   1'b0},
        '{STEP_PIXEL, '0,               '0,        24'h6496C8, 1,  1'b0, 8'd0,   1'b0},
        '{STEP_PIXEL, '0,               '0,        24'hFFFF00, 1,  1'b0, 8'd0,   1'b0},
        '{STEP_PIXEL, '0,               '0,        24'h112233, 1,  1'b0, 8'd0,   1'b0}
    };

    raster_to_block_splitter_top DUT (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .push          (pix_push),
        .i_pixel       (pix_in),
        .full          (pix_full),
        .empty         (blk_empty),
        .pop           (blk_pop),
        .o_block_pixel (blk_out)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // model
    // ------------------------------------------------------------------------
    function automatic int eff_size(int v, int hi);
        return (v < MIN_SIZE) ? MIN_SIZE : (v > hi) ? hi : v;
    endfunction

    // mirror a coordinate at or past the edge back into the image
    function automatic int fold(int c, int n);
        return (c < n) ? c : 2 * n - c - 1;
    endfunction

    // store one pixel's grey value; queue the block it completes, if any
    function automatic void split_pixel(t_pixel px, bit typed, logic [7:0] typed_grey,
                                        bit typed_frame);
        int w, h, row, col, by, bx, r, c, sum;
        bit frame_end;
        t_block_pixel bp;
        w   = eff_size(width_reg, MAX_W);
        h   = eff_size(height_reg, MAX_H);
        row = raster_row;
        col = raster_col;
        if (col >= w) col = 0;
        if (row >= h) row = 0;
        sum = px.red;
        sum += px.green;
        sum += px.blue;
        grey_store[(row % STORE_ROWS) * MAX_W + col] = 8'(sum / 3);
        if ((col % BLK == BLK - 1 || col == w - 1) && (row % BLK == BLK - 1 || row == h - 1)) begin
            by        = row - row % BLK;
            bx        = col - col % BLK;
            frame_end = (row == h - 1) && (col == w - 1);
            for (int i = 0; i < BLK; i++) begin
                for (int j = 0; j < BLK; j++) begin
                    r = fold(by + i, h);
                    c = fold(bx + j, w);
                    bp.grey       = typed ? typed_grey
                                          : grey_store[(r % STORE_ROWS) * MAX_W + (c % MAX_W)];
                    bp.block_last = (i == BLK - 1) && (j == BLK - 1);
                    bp.frame_last = bp.block_last && (typed ? typed_frame : frame_end);
                    grey_due.push_back(bp);
                end
            end
        end
        col++;
        if (col >= w) begin
            col = 0;
            row++;
            if (row >= h) row = 0;
        end
        raster_row = row;
        raster_col = col;
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        if (idx == REG_IMAGE_WIDTH) begin
            width_reg  = data[IMG_W_BITS-1:0];
            raster_row = 0;
            raster_col = 0;
        end else if (idx == REG_IMAGE_HEIGHT) begin
            height_reg = data[IMG_H_BITS-1:0];
            raster_row = 0;
            raster_col = 0;
        end
    endfunction

    function automatic logic [7:0] rand_level();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------
    // stop offering pixels, wait for every block pixel, then let the pipe empty
    task automatic settle();
        @(negedge clk);
        pix_push <= 1'b0;
        while (grey_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        apply_reg(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_pixel(t_pixel px, bit typed, logic [7:0] typed_grey, bit typed_frame);
        int gap;
        @(negedge clk);
        if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 12);
            pix_push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pix_push <= 1'b1;
        pix_in   <= px;
        do @(posedge clk); while (pix_full);
        split_pixel(px, typed, typed_grey, typed_frame);
    endtask

    task automatic run_phase(logic [CFG_DATA_W-1:0] w_data, logic [CFG_DATA_W-1:0] h_data,
                             int regs, int n_pix);
        settle();
        if (regs[0]) write_reg(REG_IMAGE_WIDTH, w_data);
        if (regs[1]) write_reg(REG_IMAGE_HEIGHT, h_data);
        repeat (n_pix) send_pixel({rand_level(), rand_level(), rand_level()}, 1'b0, 8'd0, 1'b0);
    endtask

    // ------------------------------------------------------------------------
    // receiver: random stall bursts, one long hold-off on request
    // ------------------------------------------------------------------------
    always @(negedge clk) begin
        if (!rst_n) begin
            blk_pop <= 1'b0;
        end else begin
            if (hold_go && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                blk_pop <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                blk_pop <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(1, 12) - 1;
                blk_pop <= 1'b0;
            end else begin
                blk_pop <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // result check
    // ------------------------------------------------------------------------
    always @(posedge clk) begin : check_out
        t_block_pixel want;
        if (rst_n && blk_pop && !blk_empty) begin
            if (grey_due.size() == 0) begin
                $error("block pixel with nothing expected: grey %0d", blk_out.grey);
                n_errors++;
            end else begin
                want = grey_due.pop_front();
                if (blk_out.grey !== want.grey) begin
                    $error("grey: expected %0d, got %0d", want.grey, blk_out.grey);
                    n_errors++;
                end
                if (blk_out.block_last !== want.block_last) begin
                    $error("block_last: expected %0b, got %0b", want.block_last,
                           blk_out.block_last);
                    n_errors++;
                end
                if (blk_out.frame_last !== want.frame_last) begin
                    $error("frame_last: expected %0b, got %0b", want.frame_last,
                           blk_out.frame_last);
                    n_errors++;
                end
            end
        end
    end

    // watchdog: cycles in which no request of any kind is taken
    always @(posedge clk) begin
        if (!rst_n || (pix_push && !pix_full) || (blk_pop && !blk_empty)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles++;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int w_val, h_val, w_eff, h_eff, regs, n_pix;
        logic [CFG_DATA_W-1:0] w_data;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (script[k]) begin
            if (script[k].kind == STEP_WRITE) begin
                settle();
                write_reg(script[k].index, script[k].data);
            end else begin
                repeat (script[k].reps)
                    send_pixel(script[k].px, script[k].typed, script[k].grey,
                               script[k].frame_last);
            end
        end

        // receiver holds off while an 8x9 image goes in; the lone bottom row
        // mirrors upward into the other half of the line store
        settle();
        hold_go = 1'b1;
        run_phase(CFG_DATA_W'(8), CFG_DATA_W'(9), 3, 72);

        // all-ones width with spare upper bits saturates to the widest row,
        // so nothing closes within the first row
        run_phase(13'h1FFF, 13'd0, 3, BLK);
        // narrowest row against the tallest height register value
        run_phase(13'd0, 13'h1FFF, 3, 4 * BLK);

        while (rnd_items < RAND_ITEMS) begin
            w_val  = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 12);
            h_val  = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 10);
            regs   = $urandom_range(0, 3);
            w_data = CFG_DATA_W'(w_val);
            if ($urandom_range(0, 3) == 0)
                w_data[CFG_DATA_W-1:IMG_W_BITS] = (CFG_DATA_W - IMG_W_BITS)'($urandom);
            w_eff  = regs[0] ? eff_size(w_val, MAX_W) : eff_size(width_reg, MAX_W);
            h_eff  = regs[1] ? eff_size(h_val, MAX_H) : eff_size(height_reg, MAX_H);
            case ($urandom_range(0, 2))
                0:       n_pix = w_eff * h_eff;
                1:       n_pix = $urandom_range(1, w_eff * h_eff);
                default: n_pix = w_eff * h_eff + $urandom_range(1, RAND_SPILL);
            endcase
            if (n_pix > RAND_ITEMS + RAND_SPILL - rnd_items)
                n_pix = RAND_ITEMS + RAND_SPILL - rnd_items;
            run_phase(w_data, CFG_DATA_W'(h_val), regs, n_pix);
            rnd_items += n_pix;
        end

        // closing frame at full rate, mirrored on both axes
        settle();
        calm = 1'b1;
        run_phase(CFG_DATA_W'(12), CFG_DATA_W'(5), 3, 60);
        settle();

        if (n_errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
